// File: src/pfenc_pkg.sv
// ----------------------------------------------------------------------------
// pfenc_pkg
// Shared types, codes and helper functions for the Playfair encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package pfenc_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_SEAL = 2'd1;
    localparam logic [1:0] OP_TEXT = 2'd2;
    localparam logic [1:0] OP_END  = 2'd3;

    // Letter indexes (A = 0)
    localparam logic [4:0] IDX_I    = 5'd8;
    localparam logic [4:0] IDX_J    = 5'd9;
    localparam logic [4:0] IDX_X    = 5'd23;
    localparam logic [4:0] IDX_LAST = 5'd25;

    localparam int unsigned SIDE    = 5;
    localparam int unsigned CELLS   = 25;
    localparam int unsigned LETTERS = 26;

    localparam logic [4:0] CELLS_V = 5'(CELLS);
    localparam logic [6:0] ASCII_A = 7'd65;

    typedef struct packed {
        logic place_key;   // place the folded input letter
        logic seal_start;  // clear the alphabet walk counter
        logic seal_step;   // place the walk letter and advance
        logic pend_set;    // hold the text letter as first of a pair
        logic pend_clear;  // drop the held letter
        logic pair_start;  // look up both letter positions
        logic pair_x;      // second letter of the pair is the filler X
        logic cell_read;   // look up both cipher cells
        logic out_load;    // move the two cipher letters to the output
    } pfenc_cmd_t;

    typedef struct packed {
        logic in_letter;   // input byte is an ASCII letter
        logic in_j;        // input letter is J
        logic pend_valid;  // a first letter is held
        logic pend_match;  // input text letter equals the held letter
        logic seal_done;   // walk counter is at the last letter
        logic out_empty;   // output buffer holds nothing
    } pfenc_stat_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } pfenc_rc_t;

    // Cell number 0..24 to row and column; divide by five as (pos * 13) >> 6
    function automatic pfenc_rc_t pfenc_split(input logic [4:0] pos);
        logic [8:0] prod;
        logic [4:0] col5;
        pfenc_rc_t  rc;
        prod   = {4'd0, pos} * 9'd13;
        rc.row = prod[8:6];
        col5   = pos - ({rc.row, 2'b00} + {2'b00, rc.row});
        rc.col = col5[2:0];
        return rc;
    endfunction

    function automatic logic [4:0] pfenc_cell(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    // Step one place along a row or column, wrapping at the edge
    function automatic logic [2:0] pfenc_inc5(input logic [2:0] v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

`default_nettype wire

// File: src/pfenc_ctrl.sv
// ----------------------------------------------------------------------------
// pfenc_ctrl
// Sequencer: decodes accepted items and steps the datapath through the
// alphabet walk and the two lookups of a pair.
// ----------------------------------------------------------------------------
`default_nettype none

module pfenc_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic [1:0]           s_axis_tuser,
    output logic                      s_axis_tready,
    input  wire pfenc_pkg::pfenc_stat_t stat,
    output pfenc_pkg::pfenc_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEAL = 2'd1;
    localparam logic [1:0] ST_POS  = 2'd2;
    localparam logic [1:0] ST_CELL = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_axis_tuser)
                        pfenc_pkg::OP_KEY:
                        begin
                            cmd.place_key = stat.in_letter && !stat.in_j;
                        end
                        pfenc_pkg::OP_SEAL:
                        begin
                            cmd.seal_start = 1'b1;
                            state_next     = ST_SEAL;
                        end
                        pfenc_pkg::OP_TEXT:
                        begin
                            if (stat.in_letter)
                            begin
                                if (!stat.pend_valid)
                                begin
                                    cmd.pend_set = 1'b1;
                                end
                                else
                                begin
                                    // a doubled letter pairs with X and stays held
                                    cmd.pair_start = 1'b1;
                                    cmd.pair_x     = stat.pend_match;
                                    cmd.pend_clear = !stat.pend_match;
                                    state_next     = ST_POS;
                                end
                            end
                        end
                        pfenc_pkg::OP_END:
                        begin
                            if (stat.pend_valid)
                            begin
                                cmd.pair_start = 1'b1;
                                cmd.pair_x     = 1'b1;
                                cmd.pend_clear = 1'b1;
                                state_next     = ST_POS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEAL:
            begin
                cmd.seal_step = 1'b1;
                if (stat.seal_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POS:
            begin
                cmd.cell_read = 1'b1;
                state_next    = ST_CELL;
            end
            ST_CELL:
            begin
                if (stat.out_empty)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/pfenc_datapath.sv
// ----------------------------------------------------------------------------
// pfenc_datapath
// Key square and position stores, held text letter, pair lookup and the
// two-entry output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module pfenc_datapath
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire pfenc_pkg::pfenc_cmd_t cmd,
    output pfenc_pkg::pfenc_stat_t     stat
);

    // Key square (letter per cell) and its inverse (cell per letter)
    logic [4:0] sq_mem  [pfenc_pkg::CELLS];
    logic [4:0] pos_mem [pfenc_pkg::LETTERS];

    logic [25:0] used_reg;
    logic [4:0]  fill_reg;
    logic [4:0]  seal_cnt_reg;
    logic        pend_valid_reg;
    logic [4:0]  pend_letter_reg;
    logic [4:0]  pos_a_reg;
    logic [4:0]  pos_b_reg;
    logic [4:0]  sq_x_reg;
    logic [4:0]  sq_y_reg;
    logic [6:0]  out0_reg;
    logic [6:0]  out1_reg;
    logic [1:0]  out_cnt_reg;

    logic [4:0] in_idx;
    logic       in_ok;
    logic [4:0] text_idx;
    logic [4:0] place_idx;
    logic       place_en;
    logic [4:0] pair_b;
    logic       out_take;

    pfenc_pkg::pfenc_rc_t rc_a;
    pfenc_pkg::pfenc_rc_t rc_b;
    logic [4:0] cell_x;
    logic [4:0] cell_y;

    // case folding
    always_comb
    begin
        in_ok  = 1'b1;
        in_idx = 5'd0;
        if (s_axis_tdata >= 8'd65 && s_axis_tdata <= 8'd90)
        begin
            in_idx = 5'(s_axis_tdata - 8'd65);
        end
        else if (s_axis_tdata >= 8'd97 && s_axis_tdata <= 8'd122)
        begin
            in_idx = 5'(s_axis_tdata - 8'd97);
        end
        else
        begin
            in_ok = 1'b0;
        end
    end

    assign text_idx = (in_idx == pfenc_pkg::IDX_J) ? pfenc_pkg::IDX_I : in_idx;

    assign place_idx = cmd.seal_step ? seal_cnt_reg : in_idx;
    assign place_en  = (cmd.place_key || (cmd.seal_step && seal_cnt_reg != pfenc_pkg::IDX_J))
                       && !used_reg[place_idx] && (fill_reg < pfenc_pkg::CELLS_V);

    assign pair_b = cmd.pair_x ? pfenc_pkg::IDX_X : text_idx;

    // cipher cells from the two positions
    always_comb
    begin
        rc_a = pfenc_pkg::pfenc_split(pos_a_reg);
        rc_b = pfenc_pkg::pfenc_split(pos_b_reg);
        if (rc_a.row == rc_b.row)
        begin
            cell_x = pfenc_pkg::pfenc_cell(rc_a.row, pfenc_pkg::pfenc_inc5(rc_a.col));
            cell_y = pfenc_pkg::pfenc_cell(rc_b.row, pfenc_pkg::pfenc_inc5(rc_b.col));
        end
        else if (rc_a.col == rc_b.col)
        begin
            cell_x = pfenc_pkg::pfenc_cell(pfenc_pkg::pfenc_inc5(rc_a.row), rc_a.col);
            cell_y = pfenc_pkg::pfenc_cell(pfenc_pkg::pfenc_inc5(rc_b.row), rc_b.col);
        end
        else
        begin
            cell_x = pfenc_pkg::pfenc_cell(rc_a.row, rc_b.col);
            cell_y = pfenc_pkg::pfenc_cell(rc_b.row, rc_a.col);
        end
    end

    // stores and lookup registers
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            sq_mem[fill_reg]   <= place_idx;
            pos_mem[place_idx] <= fill_reg;
        end
        if (cmd.pair_start)
        begin
            pos_a_reg <= pos_mem[pend_letter_reg];
            pos_b_reg <= pos_mem[pair_b];
        end
        if (cmd.cell_read)
        begin
            sq_x_reg <= sq_mem[cell_x];
            sq_y_reg <= sq_mem[cell_y];
        end
        if (cmd.out_load)
        begin
            out0_reg <= pfenc_pkg::ASCII_A + {2'b00, sq_x_reg};
            out1_reg <= pfenc_pkg::ASCII_A + {2'b00, sq_y_reg};
        end
    end

    assign out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= '0;
            fill_reg        <= '0;
            seal_cnt_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            out_cnt_reg     <= '0;
        end
        else
        begin
            if (place_en)
            begin
                used_reg[place_idx] <= 1'b1;
                fill_reg            <= fill_reg + 5'd1;
            end
            if (cmd.seal_start)
            begin
                seal_cnt_reg <= '0;
            end
            else if (cmd.seal_step)
            begin
                seal_cnt_reg <= seal_cnt_reg + 5'd1;
            end
            if (cmd.pend_set)
            begin
                pend_valid_reg  <= 1'b1;
                pend_letter_reg <= text_idx;
            end
            else if (cmd.pend_clear)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_cnt_reg <= 2'd2;
            end
            else if (out_take)
            begin
                out_cnt_reg <= out_cnt_reg - 2'd1;
            end
        end
    end

    assign m_axis_tvalid = (out_cnt_reg != 2'd0);
    assign m_axis_tdata  = {1'b0, (out_cnt_reg == 2'd2) ? out0_reg : out1_reg};
    assign m_axis_tlast  = (out_cnt_reg == 2'd1);

    assign stat.in_letter  = in_ok;
    assign stat.in_j       = (in_idx == pfenc_pkg::IDX_J);
    assign stat.pend_valid = pend_valid_reg;
    assign stat.pend_match = (pend_letter_reg == text_idx);
    assign stat.seal_done  = (seal_cnt_reg == pfenc_pkg::IDX_LAST);
    assign stat.out_empty  = (out_cnt_reg == 2'd0);

endmodule

`default_nettype wire

// File: src/playfair_encryptor_core.sv
// ----------------------------------------------------------------------------
// playfair_encryptor_core
// Playfair encryptor with an on-chip 5x5 key square (I and J share a cell).
// ----------------------------------------------------------------------------
// Usage and timing. Send the key as op 0 items (one ASCII letter each), then
// an op 1 item to seal the square, then text as op 2 items and op 3 to flush
// a leftover letter padded with X. Key and text letters are case-folded;
// anything that is not a letter is dropped. Each completed pair leaves as two
// output transactions, the second one flagged by tlast. A key letter, a
// dropped character, or a text letter that only opens a pair leaves the
// input ready for the next item. After its accept the seal walks over all
// 26 letters, one letter per cycle, through the single write port of the
// square stores, and takes no item meanwhile. An item that closes a pair
// holds off the next item while it steps through accept (position lookup),
// cell lookup, then the move of the two cipher letters into the output
// buffer. The two lookups are registered reads of the square stores and run
// back to back. The output buffer drains while the next items come in; a
// further pair waits at its last step until the buffer is empty. A text pair
// that names a letter not yet in the square returns undefined letters, so
// the square must be full (sealed) before text is sent.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_encryptor_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input item
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] letter
    input  wire logic [1:0] s_axis_tuser,   // [1:0] op
    // result item
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] cipher_letter, [7] zero
    output logic            m_axis_tlast    // last_of_pair
);

    pfenc_pkg::pfenc_cmd_t  cmd;
    pfenc_pkg::pfenc_stat_t stat;

    // sequencer: owns the input handshake
    pfenc_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // stores, pair lookup and output buffer
    pfenc_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

`default_nettype wire

// File: src/pfenc_checker.sv
// ----------------------------------------------------------------------------
// pfenc_checker
// Port-level checks for the Playfair encryptor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfenc_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic [1:0] s_axis_tuser,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // the first letter of a pair is always followed by the second
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
        else $error("pair split");

    // a seal walks the alphabet, so the next cycle takes no item
    a_seal_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == pfenc_pkg::OP_SEAL |=> !s_axis_tready)
        else $error("item taken during seal");

    // a key letter produces no result
    a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == pfenc_pkg::OP_KEY && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("result from key letter");

endmodule

bind playfair_encryptor_core pfenc_checker u_pfenc_checker (.*);

`default_nettype wire

// File: tb/playfair_encryptor_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// playfair_encryptor_core_tb
// Builds one key square from mixed-case key letters with J, repeats and junk
// bytes, seals it, then streams directed and random text through the
// encryptor. Every cipher letter is checked against an in-bench Playfair
// model, under three mixes of stalls on the input and output handshakes.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [6:0] letter;
    logic       last;
} cipher_char_t;

class playfair_scoreboard;
    logic [4:0]   square [25];
    logic [4:0]   cell_of [26];
    logic [25:0]  used;
    int           filled;
    bit           held_valid;
    int           held_letter;
    cipher_char_t expected_cipher [$];
    int           errors;
    int           checked;

    function new();
        used        = '0;
        filled      = 0;
        held_valid  = 1'b0;
        held_letter = 0;
        errors      = 0;
        checked     = 0;
    endfunction

    // letter index 0..25 for either case, 26 for anything else
    function int fold_ascii(logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
            return int'(ch) - 65;
        if (ch >= "a" && ch <= "z")
            return int'(ch) - 97;
        return 26;
    endfunction

    function void place_letter(int li);
        if (filled >= pfenc_pkg::CELLS || used[li])
            return;
        square[filled] = 5'(li);
        cell_of[li]    = 5'(filled);
        used[li]       = 1'b1;
        filled++;
    endfunction

    function cipher_char_t cell_char(int row, int col, logic last);
        cipher_char_t c;
        int           side;
        side     = pfenc_pkg::SIDE;
        c.letter = 7'd65 + 7'(square[(row % side) * side + (col % side)]);
        c.last   = last;
        return c;
    endfunction

    function void encipher_pair(int a, int b);
        int side;
        int ra;
        int ca;
        int rb;
        int cb;
        side = pfenc_pkg::SIDE;
        ra   = cell_of[a] / side;
        ca   = cell_of[a] % side;
        rb   = cell_of[b] / side;
        cb   = cell_of[b] % side;
        if (ra == rb)
        begin
            // same row: both shift right, each from its own column
            expected_cipher.push_back(cell_char(ra, ca + 1, 1'b0));
            expected_cipher.push_back(cell_char(rb, cb + 1, 1'b1));
        end
        else if (ca == cb)
        begin
            expected_cipher.push_back(cell_char(ra + 1, ca, 1'b0));
            expected_cipher.push_back(cell_char(rb + 1, cb, 1'b1));
        end
        else
        begin
            expected_cipher.push_back(cell_char(ra, cb, 1'b0));
            expected_cipher.push_back(cell_char(rb, ca, 1'b1));
        end
    endfunction

    // Called once per accepted input transaction
    function void record_item(logic [1:0] op, logic [7:0] ch);
        int li;
        li = fold_ascii(ch);
        case (op)
            pfenc_pkg::OP_KEY:
            begin
                if (li < 26 && li != int'(pfenc_pkg::IDX_J))
                    place_letter(li);
            end
            pfenc_pkg::OP_SEAL:
            begin
                for (int i = 0; i < 26; i++)
                    if (i != int'(pfenc_pkg::IDX_J))
                        place_letter(i);
            end
            pfenc_pkg::OP_TEXT:
            begin
                if (li < 26)
                begin
                    if (li == int'(pfenc_pkg::IDX_J))
                        li = int'(pfenc_pkg::IDX_I);
                    if (!held_valid)
                    begin
                        held_valid  = 1'b1;
                        held_letter = li;
                    end
                    else if (held_letter == li)
                    begin
                        // doubled letter: pad with X, the letter stays held
                        encipher_pair(held_letter, int'(pfenc_pkg::IDX_X));
                    end
                    else
                    begin
                        held_valid = 1'b0;
                        encipher_pair(held_letter, li);
                    end
                end
            end
            default:
            begin
                if (held_valid)
                begin
                    held_valid = 1'b0;
                    encipher_pair(held_letter, int'(pfenc_pkg::IDX_X));
                end
            end
        endcase
    endfunction

    // Called once per accepted output transaction
    function void check_cipher(logic [7:0] data, logic last);
        cipher_char_t exp;
        if (expected_cipher.size() == 0)
        begin
            $display("%0t: unexpected cipher output, data %h last %b", $time, data, last);
            errors++;
            return;
        end
        exp = expected_cipher.pop_front();
        checked++;
        if (data !== {1'b0, exp.letter})
        begin
            $display("%0t: cipher letter mismatch, expected %h actual %h",
                     $time, {1'b0, exp.letter}, data);
            errors++;
        end
        if (last !== exp.last)
        begin
            $display("%0t: last_of_pair mismatch, expected %b actual %b",
                     $time, exp.last, last);
            errors++;
        end
    endfunction
endclass

module playfair_encryptor_core_tb;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;              // [7:0] letter
    logic [1:0] s_axis_tuser  = pfenc_pkg::OP_KEY; // [1:0] op
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;                      // [6:0] cipher_letter, [7] zero
    logic       m_axis_tlast;                      // last_of_pair

    playfair_scoreboard sb;
    int send_idle;
    int recv_idle;
    int items_sent;
    int text_items;

    playfair_encryptor_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output side: random back-pressure, check every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_cipher(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Drive one input transaction; returns in the step of the accepting edge
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tuser  <= 2'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sb.record_item(op, ch);
        items_sent++;
    endtask

    // Random traffic: mostly text letters with forced doubles and X, plus ends,
    // junk bytes, key letters and seals that the full square must ignore
    task automatic run_phase(input int n_text);
        int         done;
        int         roll;
        int         li;
        int         prev_li;
        logic [7:0] ch;
        done    = 0;
        prev_li = 0;
        while (done < n_text)
        begin
            roll = $urandom_range(99);
            if (roll < 72)
            begin
                if ($urandom_range(9) == 0)
                    li = prev_li;
                else if ($urandom_range(19) == 0)
                    li = int'(pfenc_pkg::IDX_X);
                else
                    li = $urandom_range(25);
                prev_li = li;
                ch = 8'd65 + 8'(li);
                if ($urandom_range(1))
                    ch = ch | 8'h20;
                send_item(pfenc_pkg::OP_TEXT, ch);
                done++;
            end
            else if (roll < 80)
            begin
                send_item(pfenc_pkg::OP_END, 8'($urandom));
                done++;
            end
            else if (roll < 88)
                send_item(pfenc_pkg::OP_TEXT, 8'($urandom));
            else if (roll < 95)
                send_item(pfenc_pkg::OP_KEY, 8'($urandom));
            else
                send_item(pfenc_pkg::OP_SEAL, 8'($urandom));
        end
        text_items += done;
    endtask

    initial
    begin
        sb         = new();
        send_idle  = 16;
        recv_idle  = 53;
        items_sent = 0;
        text_items = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Key with mixed case, a J, a repeat and junk bytes
        send_item(pfenc_pkg::OP_KEY, "P");
        send_item(pfenc_pkg::OP_KEY, "l");
        send_item(pfenc_pkg::OP_KEY, "a");
        send_item(pfenc_pkg::OP_KEY, "J");
        send_item(pfenc_pkg::OP_KEY, "y");
        send_item(pfenc_pkg::OP_KEY, "f");
        send_item(pfenc_pkg::OP_KEY, "a");
        send_item(pfenc_pkg::OP_KEY, "i");
        send_item(pfenc_pkg::OP_KEY, 8'hFF);
        send_item(pfenc_pkg::OP_KEY, 8'h00);
        // a text letter may open a pair before the square is full
        send_item(pfenc_pkg::OP_TEXT, "h");
        send_item(pfenc_pkg::OP_KEY, "E");
        send_item(pfenc_pkg::OP_SEAL, 8'h00);
        send_item(pfenc_pkg::OP_SEAL, 8'hFF);
        send_item(pfenc_pkg::OP_KEY, "z");
        // close the held pair, then column, J as I, doubled letter, flushes
        send_item(pfenc_pkg::OP_TEXT, "D");
        send_item(pfenc_pkg::OP_TEXT, "p");
        send_item(pfenc_pkg::OP_TEXT, "I");
        send_item(pfenc_pkg::OP_TEXT, "j");
        send_item(pfenc_pkg::OP_TEXT, "i");
        send_item(pfenc_pkg::OP_END, 8'hA5);
        send_item(pfenc_pkg::OP_END, 8'h5A);
        send_item(pfenc_pkg::OP_TEXT, "5");
        send_item(pfenc_pkg::OP_TEXT, "x");
        send_item(pfenc_pkg::OP_TEXT, "X");
        send_item(pfenc_pkg::OP_TEXT, "z");

        run_phase(406);
        send_idle = 53;
        recv_idle = 16;
        run_phase(406);
        send_idle = 0;
        recv_idle = 0;
        run_phase(406);
        s_axis_tvalid <= 1'b0;

        while (sb.expected_cipher.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d input transactions (%0d random text/end items) over three stall mixes",
                 items_sent, text_items);
        $display("Checked %0d cipher letters from one sealed key square", sb.checked);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d cipher letters still expected", sb.expected_cipher.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
